[rtl/core/smcc_pkg.sv]
package smcc_pkg;

   localparam int CACHES_DEFAULT = 4;
   localparam int LINES_DEFAULT  = 64;

   localparam int ADDR_W    = 32;
   localparam int TAG_W     = 26;
   localparam int DATA_W    = 64;
   localparam int LINE_OFS  = 6;
   localparam int CSR_W     = 3;
   localparam int MOD_STEPS = 2;

   localparam logic [1:0] KIND_READ        = 2'd0;
   localparam logic [1:0] KIND_WRITE       = 2'd1;
   localparam logic [1:0] KIND_SNOOP_READ  = 2'd2;
   localparam logic [1:0] KIND_SNOOP_WRITE = 2'd3;

   localparam logic [1:0] MODE_MSI   = 2'd0;
   localparam logic [1:0] MODE_MESI  = 2'd1;
   localparam logic [1:0] MODE_MOESI = 2'd2;

   localparam logic CSR_PROTOCOL    = 1'b0;
   localparam logic CSR_CACHE_COUNT = 1'b1;

   localparam logic [2:0] CACHE_COUNT_RESET = 3'd4;

   typedef enum logic [1:0] {
      COH_I = 2'd0,
      COH_S = 2'd1,
      COH_E = 2'd2,
      COH_M = 2'd3
   } coh_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        requester;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic              error;
      logic              hit;
      logic              bus_transaction;
      logic [DATA_W-1:0] read_data;
      logic [1:0]        line_state;
      logic [1:0]        writeback_count;
      logic [1:0]        invalidation_count;
   } rsp_type;

   typedef struct packed {
      coh_type           coh;
      logic [TAG_W-1:0]  tag;
      logic [DATA_W-1:0] payload;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_OWN_RD,
      ST_OWN_CHK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic own_read;
      logic own_check;
      logic scan_read;
      logic scan_check;
      logic scan_next;
      logic finish;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic mod_done;
      logic own_done;
      logic scan_self;
      logic scan_last;
      logic supplied;
      logic clear_done;
   } status_type;

endpackage

[rtl/core/smcc_ctrl.sv]
module smcc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output smcc_pkg::cmd_type    cmd,
   input  smcc_pkg::status_type status
);

   smcc_pkg::state_type state_ff;
   smcc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smcc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smcc_pkg::ST_CLEAR: begin
            if (status.clear_done) state_in = smcc_pkg::ST_IDLE;
         end
         smcc_pkg::ST_IDLE: begin
            if (start) state_in = smcc_pkg::ST_MOD;
         end
         smcc_pkg::ST_MOD: begin
            if (status.err) state_in = smcc_pkg::ST_RESP;
            else if (status.mod_done) state_in = smcc_pkg::ST_OWN_RD;
         end
         smcc_pkg::ST_OWN_RD: state_in = smcc_pkg::ST_OWN_CHK;
         smcc_pkg::ST_OWN_CHK: begin
            state_in = status.own_done ? smcc_pkg::ST_RESP : smcc_pkg::ST_SCAN_RD;
         end
         smcc_pkg::ST_SCAN_RD: begin
            if (!status.scan_self) state_in = smcc_pkg::ST_SCAN_CHK;
            else if (status.scan_last) state_in = smcc_pkg::ST_FINISH;
         end
         smcc_pkg::ST_SCAN_CHK: begin
            state_in = (status.supplied || status.scan_last) ? smcc_pkg::ST_FINISH
                                                             : smcc_pkg::ST_SCAN_RD;
         end
         smcc_pkg::ST_FINISH: state_in = smcc_pkg::ST_RESP;
         smcc_pkg::ST_RESP:   state_in = smcc_pkg::ST_IDLE;
         default:             state_in = smcc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         smcc_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         smcc_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         smcc_pkg::ST_MOD:     cmd.mod_step  = !status.err;
         smcc_pkg::ST_OWN_RD:  cmd.own_read  = 1'b1;
         smcc_pkg::ST_OWN_CHK: cmd.own_check = 1'b1;
         smcc_pkg::ST_SCAN_RD: begin
            cmd.scan_read = !status.scan_self;
            cmd.scan_next = status.scan_self;
         end
         smcc_pkg::ST_SCAN_CHK: begin
            cmd.scan_check = 1'b1;
            cmd.scan_next  = !(status.supplied || status.scan_last);
         end
         smcc_pkg::ST_FINISH: cmd.finish = 1'b1;
         smcc_pkg::ST_RESP:   rsp_valid  = 1'b1;
         default:             busy       = 1'b1;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("response not followed by idle");
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy && !rsp_valid)
      else $error("accepted transaction did not start work");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.own_read, cmd.scan_read, cmd.own_check, cmd.scan_check, cmd.finish,
                cmd.clear_step}))
      else $error("conflicting memory commands");

endmodule

[rtl/core/smcc_datapath.sv]
module smcc_datapath #(
   parameter int CACHES = smcc_pkg::CACHES_DEFAULT,
   parameter int LINES  = smcc_pkg::LINES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smcc_pkg::req_type              req_item,
   output smcc_pkg::rsp_type              rsp_item,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [smcc_pkg::CSR_W-1:0]    csr_write_data,
   input  smcc_pkg::cmd_type              cmd,
   output smcc_pkg::status_type           status
);

   localparam int CW     = $clog2(CACHES);
   localparam int NW     = CW + 1;
   localparam int IW     = $clog2(LINES);
   localparam int AW     = CW + IW;
   localparam int DEPTH  = 2 ** AW;
   localparam int RS     = smcc_pkg::TAG_W + IW;
   localparam int PROD_W = 2 * smcc_pkg::TAG_W + 1;
   localparam longint unsigned RECIP_WIDE =
      ((64'd1 << RS) + 64'(LINES) - 64'd1) / 64'(LINES);
   localparam logic [smcc_pkg::TAG_W:0] RECIP = (smcc_pkg::TAG_W + 1)'(RECIP_WIDE);

   smcc_pkg::entry_type mem [DEPTH];

   smcc_pkg::req_type            item_ff;
   logic [1:0]                   protocol_ff;
   logic [2:0]                   count_ff;
   logic [IW-1:0]                rem_ff;
   logic [IW-1:0]                rem_in;
   logic [PROD_W-1:0]            prod_ff;
   logic [2:0]                   modcnt_ff;
   logic [CW-1:0]                scan_ff;
   logic [AW:0]                  clr_ff;
   smcc_pkg::entry_type          rd_ff;
   logic                         hit_ff;
   logic                         bus_ff;
   logic [smcc_pkg::DATA_W-1:0]  rdata_ff;
   logic [1:0]                   lstate_ff;
   logic [1:0]                   wb_ff;
   logic [1:0]                   inv_ff;
   logic                         shared_ff;
   logic [smcc_pkg::DATA_W-1:0]  buf_ff;

   logic [smcc_pkg::TAG_W-1:0]     tag;
   logic [smcc_pkg::TAG_W-1:0]     quot;
   logic [NW-1:0]                  in_use;
   logic                           err;
   logic                           excl;
   logic [AW-1:0]                  own_addr;
   logic [AW-1:0]                  scan_addr;
   logic                           match;
   logic                           rd_mod;
   logic                           we;
   logic [AW-1:0]                  waddr;
   smcc_pkg::entry_type            wentry;

   assign tag    = item_ff.address[smcc_pkg::ADDR_W-1:smcc_pkg::LINE_OFS];
   assign quot   = smcc_pkg::TAG_W'(prod_ff >> RS);
   assign rem_in = IW'(tag - smcc_pkg::TAG_W'(quot * smcc_pkg::TAG_W'(LINES)));

   assign in_use = (int'(count_ff) < CACHES) ? NW'(count_ff) : NW'(CACHES);
   assign err    = int'(item_ff.requester) >= int'(in_use);
   assign excl   = (protocol_ff == smcc_pkg::MODE_MESI) ||
                   (protocol_ff == smcc_pkg::MODE_MOESI);

   assign own_addr  = {CW'(item_ff.requester), rem_ff};
   assign scan_addr = {scan_ff, rem_ff};
   assign match     = (rd_ff.coh != smcc_pkg::COH_I) && (rd_ff.tag == tag);
   assign rd_mod    = rd_ff.coh == smcc_pkg::COH_M;

   always_comb begin
      status            = '0;
      status.err        = err;
      status.mod_done   = modcnt_ff == 3'(smcc_pkg::MOD_STEPS - 1);
      status.own_done   = (item_ff.kind == smcc_pkg::KIND_SNOOP_READ) ||
                          (item_ff.kind == smcc_pkg::KIND_SNOOP_WRITE) ||
                          ((item_ff.kind == smcc_pkg::KIND_READ) && match) ||
                          ((item_ff.kind == smcc_pkg::KIND_WRITE) && match &&
                           (rd_mod || (rd_ff.coh == smcc_pkg::COH_E)));
      status.scan_self  = scan_ff == CW'(item_ff.requester);
      status.scan_last  = ({1'b0, scan_ff} + NW'(1)) >= in_use;
      status.supplied   = (item_ff.kind == smcc_pkg::KIND_READ) && match && rd_mod;
      status.clear_done = clr_ff == (AW + 1)'(DEPTH - 1);
   end

   always_comb begin
      we     = 1'b0;
      waddr  = own_addr;
      wentry = '{coh: smcc_pkg::COH_M, tag: tag, payload: item_ff.write_data};
      if (cmd.clear_step) begin
         we         = 1'b1;
         waddr      = clr_ff[AW-1:0];
         wentry.coh = smcc_pkg::COH_I;
      end else if (cmd.own_check) begin
         if (item_ff.kind == smcc_pkg::KIND_WRITE) begin
            we = status.own_done;
         end else if (item_ff.kind == smcc_pkg::KIND_SNOOP_WRITE) begin
            we         = match;
            wentry     = rd_ff;
            wentry.coh = smcc_pkg::COH_I;
         end
      end else if (cmd.scan_check) begin
         we     = match && (item_ff.kind == smcc_pkg::KIND_READ ||
                            item_ff.kind == smcc_pkg::KIND_WRITE);
         waddr  = scan_addr;
         wentry = rd_ff;
         wentry.coh = (item_ff.kind == smcc_pkg::KIND_READ) ? smcc_pkg::COH_S
                                                            : smcc_pkg::COH_I;
      end else if (cmd.finish) begin
         we = 1'b1;
         if (item_ff.kind == smcc_pkg::KIND_READ) begin
            if (wb_ff != 2'd0) begin
               wentry.coh     = smcc_pkg::COH_S;
               wentry.payload = buf_ff;
            end else begin
               wentry.coh     = (excl && !shared_ff) ? smcc_pkg::COH_E : smcc_pkg::COH_S;
               wentry.payload = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wentry;
      if (cmd.own_read) rd_ff <= mem[own_addr];
      else if (cmd.scan_read) rd_ff <= mem[scan_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_ff <= smcc_pkg::MODE_MESI;
         count_ff    <= smcc_pkg::CACHE_COUNT_RESET;
         clr_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == smcc_pkg::CSR_PROTOCOL) protocol_ff <= csr_write_data[1:0];
            else count_ff <= csr_write_data;
         end
         if (cmd.clear_step) clr_ff <= clr_ff + (AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modcnt_ff <= '0;
         scan_ff   <= '0;
      end else if (cmd.load) begin
         modcnt_ff <= '0;
         scan_ff   <= '0;
      end else begin
         if (cmd.mod_step) modcnt_ff <= modcnt_ff + 3'd1;
         if (cmd.scan_next) scan_ff <= scan_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff   <= req_item;
         rem_ff    <= '0;
         hit_ff    <= 1'b0;
         bus_ff    <= 1'b0;
         rdata_ff  <= '0;
         lstate_ff <= 2'd0;
         wb_ff     <= 2'd0;
         inv_ff    <= 2'd0;
         shared_ff <= 1'b0;
      end
      if (cmd.mod_step) begin
         if (status.mod_done) rem_ff <= rem_in;
         else prod_ff <= PROD_W'(tag) * PROD_W'(RECIP);
      end
      if (cmd.own_check) begin
         if (status.own_done) begin
            hit_ff <= match;
            case (item_ff.kind)
               smcc_pkg::KIND_READ: begin
                  rdata_ff  <= rd_ff.payload;
                  lstate_ff <= rd_ff.coh;
               end
               smcc_pkg::KIND_WRITE:       lstate_ff <= smcc_pkg::COH_M;
               smcc_pkg::KIND_SNOOP_READ:  lstate_ff <= match ? rd_ff.coh : smcc_pkg::COH_I;
               default:                    lstate_ff <= smcc_pkg::COH_I;
            endcase
         end else begin
            bus_ff <= 1'b1;
         end
      end
      if (cmd.scan_check && match) begin
         if (item_ff.kind == smcc_pkg::KIND_READ) begin
            if (rd_mod) begin
               buf_ff <= rd_ff.payload;
               wb_ff  <= 2'd1;
            end else begin
               shared_ff <= 1'b1;
            end
         end else begin
            if (rd_mod && wb_ff != 2'd3) wb_ff <= wb_ff + 2'd1;
            if (inv_ff != 2'd3) inv_ff <= inv_ff + 2'd1;
         end
      end
      if (cmd.finish) begin
         lstate_ff <= wentry.coh;
         if (item_ff.kind == smcc_pkg::KIND_READ) rdata_ff <= wentry.payload;
      end
   end

   always_comb begin
      rsp_item = '0;
      if (err) begin
         rsp_item.error = 1'b1;
      end else begin
         rsp_item.hit                = hit_ff;
         rsp_item.bus_transaction    = bus_ff;
         rsp_item.read_data          = rdata_ff;
         rsp_item.line_state         = lstate_ff;
         rsp_item.writeback_count    = wb_ff;
         rsp_item.invalidation_count = inv_ff;
      end
   end

endmodule

[rtl/core/snoopy_mesi_coherence_controller.sv]
// Snooping MESI coherence controller for CACHES direct-mapped caches of LINES lines.
// Request channel: drive start with req_item (kind, requester, address, write_data);
// the transaction is taken on a clock edge where start is high and busy is low.
// Result channel: rsp_valid is high for exactly one cycle with rsp_item; the
// receiver cannot stall, so it must take the result in that cycle.
// Configuration: csr_write_enable, csr_index (0 protocol, 1 cache_count) and
// csr_write_data write a register at the clock edge; write only while idle.
// Sequence: the line index is the tag modulo LINES, found by a reciprocal multiply
// (product registered, then remainder), then one lookup read and one check of the
// requester's line. Hits and snoops respond after that check; an error (requester
// not among the caches in use) responds without the lookup. A miss scans the other
// caches in use, a read and an update per cache, skipping the requester itself, then
// writes the line; a Modified copy that supplies a read ends the scan early.
// Busy stays high through the result cycle and the next transaction is taken in the
// cycle after it at the earliest, so one transaction is finished before the next.
// Reset is synchronous; after it the line state memory is cleared one entry per
// cycle over all 2**(clog2(CACHES) + clog2(LINES)) entries, with busy high.
module snoopy_mesi_coherence_controller #(
   parameter int CACHES = smcc_pkg::CACHES_DEFAULT,
   parameter int LINES  = smcc_pkg::LINES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  smcc_pkg::req_type            req_item,
   output logic                        rsp_valid,
   output smcc_pkg::rsp_type            rsp_item,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [smcc_pkg::CSR_W-1:0]  csr_write_data
);

   smcc_pkg::cmd_type    cmd;
   smcc_pkg::status_type status;

   smcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   smcc_datapath #(
      .CACHES (CACHES),
      .LINES  (LINES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_item         (req_item),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.error |-> !rsp_item.hit && !rsp_item.bus_transaction)
      else $error("error response carries results");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.hit && rsp_item.bus_transaction))
      else $error("hit and bus transaction together");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.writeback_count != 2'd0) |-> rsp_item.bus_transaction)
      else $error("writeback without bus transaction");

endmodule
